// ===== rtl/core/lfc_pkg.sv =====
`timescale 1ns / 1ps

package lfc_pkg;

  localparam int MAG_W      = 14;
  localparam int DIR_W      = 16;
  localparam int G_W        = 16;
  localparam int AG_W       = 14;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_MAG = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_TOL = 2'd1;

  localparam logic [MAG_W-1:0] MIN_MAG_RESET = 14'd100;
  localparam logic [DIR_W-1:0] DIR_TOL_RESET = 16'd500;

  localparam logic signed [G_W-1:0] G_LIMIT = 16'sd8192;
  localparam int unsigned FULL_SCALE = 10000;

  // divide by five: multiply by reciprocal, exact for |x| < 2^18
  localparam logic [15:0] RECIP_5     = 16'd52429;
  localparam int          RECIP_SHIFT = 18;

  typedef struct packed {
    logic load;
    logic lookup;
    logic accum;
    logic div_start;
    logic div_step;
    logic decide;
  } lfc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_full;
  } lfc_status_t;

  // float with 32-bit normalized mantissa, used only to build the curve rom
  typedef struct packed {
    logic [31:0] m;
    int          e;
  } bfl_t;

  function automatic bfl_t bfl_from(input logic [31:0] v);
    bfl_t r;
    r.m = v;
    r.e = 0;
    if (v != 32'd0) begin
      for (int i = 0; i < 32; i++) begin
        if (r.m[31] == 1'b0) begin
          r.m = r.m << 1;
          r.e = r.e - 1;
        end
      end
    end
    return r;
  endfunction

  function automatic bfl_t bfl_mul(input bfl_t a, input bfl_t b);
    bfl_t        r;
    logic [63:0] p;
    if (a.m == 32'd0 || b.m == 32'd0) begin
      r = bfl_from(32'd0);
    end else begin
      p   = {32'd0, a.m} * {32'd0, b.m};
      r.e = a.e + b.e;
      if (p[63]) begin
        r.m = p[63:32];
        r.e = r.e + 32;
      end else begin
        r.m = p[62:31];
        r.e = r.e + 31;
      end
    end
    return r;
  endfunction

  function automatic bfl_t bfl_pow(input logic [31:0] v, input int n);
    bfl_t b;
    bfl_t r;
    b = bfl_from(v);
    r = bfl_from(32'd1);
    for (int i = 0; i < n; i++) begin
      r = bfl_mul(r, b);
    end
    return r;
  endfunction

  function automatic logic bfl_le(input bfl_t a, input bfl_t b);
    logic res;
    if (a.m == 32'd0) res = 1'b1;
    else if (b.m == 32'd0) res = 1'b0;
    else if (a.e != b.e) res = (a.e < b.e);
    else res = (a.m <= b.m);
    return res;
  endfunction

  // largest y with y^20 * 2^(17*bits) <= 10000^20 * idx^17
  function automatic logic [MAG_W-1:0] curve_entry(input int unsigned idx, input int bits);
    bfl_t        rhs;
    bfl_t        lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = FULL_SCALE;
    if (idx != 0) begin
      rhs = bfl_mul(bfl_pow(FULL_SCALE, 20), bfl_pow(idx, 17));
      for (int i = 0; i < 16; i++) begin
        if (lo < hi) begin
          mid   = (lo + hi + 1) / 2;
          lhs   = bfl_pow(mid, 20);
          lhs.e = lhs.e + 17 * bits;
          if (bfl_le(lhs, rhs)) lo = mid;
          else hi = mid - 1;
        end
      end
    end
    return lo[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lfc_ctrl.sv =====
`timescale 1ns / 1ps

module lfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  lfc_pkg::lfc_status_t status,
  output lfc_pkg::lfc_cmd_t    cmd
);
  import lfc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_LOOKUP    = 6'b000010,
    ST_ACCUM     = 6'b000100,
    ST_DIV_START = 6'b001000,
    ST_DIV_RUN   = 6'b010000,
    ST_DECIDE    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_tready      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // hold while the previous word is still waiting downstream
        if (!status.out_full) begin
          cmd.decide = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lfc_datapath.sv =====
`timescale 1ns / 1ps

module lfc_datapath #(
  parameter int HISTORY_DEPTH    = 5,
  parameter int CURVE_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [31:0]                       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,
  input  logic                              cfg_wen,
  input  logic [lfc_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [lfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  lfc_pkg::lfc_cmd_t                 cmd,
  output lfc_pkg::lfc_status_t              status
);
  import lfc_pkg::*;

  localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W     = MAG_W + FILL_W;
  localparam int CNT_W     = $clog2(SUM_W + 1);
  localparam int IDX_W     = CURVE_TABLE_BITS + 1;
  localparam int ROM_DEPTH = (1 << CURVE_TABLE_BITS) + 1;
  localparam int ABS_W     = 18;
  localparam int PROD_W    = ABS_W + 16;

  // configuration
  logic [MAG_W-1:0] min_mag;
  logic [DIR_W-1:0] dir_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mag <= MIN_MAG_RESET;
      dir_tol <= DIR_TOL_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MIN_MAG: min_mag <= cfg_data[MAG_W-1:0];
        CFG_DIR_TOL: dir_tol <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // curve rom
  logic [MAG_W-1:0] curve_rom [ROM_DEPTH];

  for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = curve_entry(gi, CURVE_TABLE_BITS);
    assign curve_rom[gi] = ENTRY;
  end

  // input capture
  logic signed [G_W-1:0]   g_in;
  logic signed [DIR_W-1:0] target;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      g_in   <= s_tdata[15:0];
      target <= s_tdata[31:16];
    end
  end

  // clamp, magnitude and rom index
  logic signed [G_W-1:0] g_clamped;
  logic [AG_W-1:0]       ag;
  logic [IDX_W-1:0]      rom_idx;

  always_comb begin
    if (g_in > G_LIMIT) g_clamped = G_LIMIT;
    else if (g_in < -G_LIMIT) g_clamped = -G_LIMIT;
    else g_clamped = g_in;
    ag      = g_clamped[G_W-1] ? AG_W'(-g_clamped) : AG_W'(g_clamped);
    rom_idx = IDX_W'(ag >> (AG_W - 1 - CURVE_TABLE_BITS));
  end

  // direction blend: (4*b + t) / 5 toward zero
  logic signed [DIR_W-1:0] blended;
  logic signed [ABS_W:0]   blend_num;
  logic [ABS_W-1:0]        blend_abs;
  logic [PROD_W-1:0]       blend_prod;
  logic                    blend_neg;
  logic [DIR_W-1:0]        blend_q;

  assign blend_num = ((ABS_W + 1)'(blended) <<< 2) + (ABS_W + 1)'(target);
  assign blend_abs = blend_num[ABS_W] ? ABS_W'(-blend_num) : ABS_W'(blend_num);
  assign blend_q   = DIR_W'(blend_prod >> RECIP_SHIFT);

  logic [MAG_W-1:0] curved;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      curved     <= curve_rom[rom_idx];
      blend_prod <= {16'd0, blend_abs} * {{ABS_W{1'b0}}, RECIP_5};
      blend_neg  <= blend_num[ABS_W];
    end
  end

  // history
  logic [MAG_W-1:0]  ring [HISTORY_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  sum;
  logic              ring_full;

  assign ring_full = (fill == FILL_W'(HISTORY_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      ring[slot] <= curved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      slot    <= '0;
      sum     <= '0;
      blended <= '0;
    end else if (cmd.accum) begin
      if (!ring_full) begin
        fill <= fill + FILL_W'(1);
        sum  <= sum + SUM_W'(curved);
      end else begin
        sum  <= sum - SUM_W'(ring[slot]) + SUM_W'(curved);
      end
      slot    <= (slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
      blended <= blend_neg ? -blend_q : blend_q;
    end
  end

  // bit-serial restoring divider: sum / fill
  logic [SUM_W-1:0]  quo;
  logic [FILL_W-1:0] rem;
  logic [CNT_W-1:0]  div_cnt;
  logic [FILL_W:0]   shifted;
  logic [FILL_W+1:0] trial;

  assign shifted = {rem, quo[SUM_W-1]};
  assign trial   = {1'b0, shifted} - (FILL_W + 2)'(fill);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo     <= sum;
      rem     <= '0;
      div_cnt <= CNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - CNT_W'(1);
      if (!trial[FILL_W+1]) begin
        rem <= trial[FILL_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[FILL_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign status.div_last = (div_cnt == CNT_W'(1));
  assign status.out_full = m_tvalid & ~m_tready;

  // update decision
  logic signed [MAG_W+1:0]  last_sent;
  logic [MAG_W-1:0]         mag;
  logic signed [MAG_W+1:0]  dm;
  logic [MAG_W+1:0]         dm_abs;
  logic signed [DIR_W:0]    dd;
  logic [DIR_W:0]           dd_abs;
  logic                     emit;

  assign mag    = quo[MAG_W-1:0];
  assign dm     = $signed({2'b00, mag}) - last_sent;
  assign dm_abs = dm[MAG_W+1] ? (MAG_W + 2)'(-dm) : (MAG_W + 2)'(dm);
  assign dd     = (DIR_W + 1)'(blended) - (DIR_W + 1)'(target);
  assign dd_abs = dd[DIR_W] ? (DIR_W + 1)'(-dd) : (DIR_W + 1)'(dd);
  assign emit   = (dm_abs >= (MAG_W + 2)'(min_mag)) || (dd_abs >= (DIR_W + 1)'(dir_tol));

  logic [MAG_W-1:0] out_mag;
  logic [DIR_W-1:0] out_dir;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sent <= '1;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.decide && emit) begin
        last_sent <= $signed({2'b00, mag});
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && emit) begin
      out_mag <= mag;
      out_dir <= blended;
    end
  end

  assign m_tdata = {2'b00, out_dir, out_mag};

endmodule

// ===== rtl/core/lateral_force_conditioner.sv =====
`timescale 1ns / 1ps
// sequencing: an input word passes the load, lookup, accumulate, divider start,
//   divider run and decide states; sum width SUM_W = 14 + clog2(HISTORY_DEPTH + 1)
// input: a new word is taken only in idle, after the previous one is decided; the
//   one-bit-per-cycle divider takes the history mean, and decide waits on a full output
// reset: synchronous, clears history, blend and output valid; last magnitude reads -1

module lateral_force_conditioner #(
  parameter int HISTORY_DEPTH    = 5,
  parameter int CURVE_TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // lateral_g, target_direction
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // force_magnitude, force_direction, pad
  input  logic                           cfg_wen,
  input  logic [lfc_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfc_pkg::*;

  lfc_cmd_t    cmd;
  lfc_status_t status;

  lfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lfc_datapath #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .CURVE_TABLE_BITS (CURVE_TABLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== bench/lateral_force_conditioner_tb.sv =====
`timescale 1ns / 1ps

module lateral_force_conditioner_tb;

  import lfc_pkg::*;

  localparam int HIST_DEPTH  = 5;
  localparam int CURVE_BITS  = 10;
  localparam int CURVE_SIZE  = (1 << CURVE_BITS) + 1;
  localparam int FULL_FORCE  = 10000;
  localparam int G_CLAMP     = 8192;
  localparam int N_DIRECTED  = 20;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int SETTLE_CYC  = 48;
  localparam int MAX_PRINTS  = 40;
  localparam int EXP_DEPTH   = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE0 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE1 = 2'd3;

  typedef struct packed {
    logic signed [15:0] g;
    logic signed [15:0] tgt;
    bit                 typed;
    bit                 emits;
    bit [13:0]          mag;
    logic signed [15:0] dir;
  } stim_row_t;

  typedef struct {
    bit [13:0]          mag;
    logic signed [15:0] dir;
  } force_word_t;

  typedef struct {
    bit [31:0] mant;
    int        expo;
  } fpnum_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // lateral_g, target_direction
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;   // force_magnitude, force_direction, pad
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lateral_force_conditioner DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // force model state
  int curve_lut [CURVE_SIZE];
  int hist [HIST_DEPTH];
  int hist_fill;
  int hist_slot;
  int hist_sum;
  int blend_dir;
  int last_sent_mag;
  int min_change;
  int dir_tol;

  // expected words in order of arrival
  force_word_t exp_words [EXP_DEPTH];
  int          exp_head;
  int          exp_tail;
  int          exp_count;

  stim_row_t directed_rows [N_DIRECTED];

  bit                 row_typed;
  bit                 row_emits;
  bit [13:0]          row_mag;
  logic signed [15:0] row_dir;
  bit                 quiet;

  int errors;
  int items_sent;
  int results_seen;
  int suppressed;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results still pending", exp_count);
    $display("lateral_force_conditioner_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTS) $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic queue_word(input force_word_t w);
    if (exp_count == EXP_DEPTH) begin
      report_mismatch("too many expected words outstanding");
    end else begin
      exp_words[exp_tail] = w;
      exp_tail = (exp_tail + 1) % EXP_DEPTH;
      exp_count++;
    end
  endtask

  // truncating float with a 32-bit normalized mantissa
  function automatic fpnum_t fp_of(input bit [31:0] v);
    fpnum_t r;
    r.mant = v;
    r.expo = 0;
    if (v != 0) begin
      while (!r.mant[31]) begin
        r.mant = r.mant << 1;
        r.expo--;
      end
    end
    return r;
  endfunction

  function automatic fpnum_t fp_mul(input fpnum_t a, input fpnum_t b);
    fpnum_t          r;
    longint unsigned p;
    if (a.mant == 0 || b.mant == 0) return fp_of(0);
    p = longint'(a.mant) * longint'(b.mant);
    r.expo = a.expo + b.expo;
    if (p[63]) begin
      r.mant = p[63:32];
      r.expo = r.expo + 32;
    end else begin
      r.mant = p[62:31];
      r.expo = r.expo + 31;
    end
    return r;
  endfunction

  function automatic fpnum_t fp_pow(input bit [31:0] v, input int n);
    fpnum_t b;
    fpnum_t r;
    b = fp_of(v);
    r = fp_of(1);
    repeat (n) r = fp_mul(r, b);
    return r;
  endfunction

  function automatic bit fp_le(input fpnum_t a, input fpnum_t b);
    if (a.mant == 0) return 1'b1;
    if (b.mant == 0) return 1'b0;
    if (a.expo != b.expo) return a.expo < b.expo;
    return a.mant <= b.mant;
  endfunction

  // largest y with (y/10000)^20 <= (idx/2^bits)^17
  function automatic int curve_value(input int idx);
    fpnum_t rhs;
    fpnum_t lhs;
    int     lo;
    int     hi;
    int     mid;
    lo = 0;
    hi = FULL_FORCE;
    if (idx == 0) return 0;
    rhs = fp_mul(fp_pow(FULL_FORCE, 20), fp_pow(idx, 17));
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = fp_pow(mid, 20);
      lhs.expo = lhs.expo + 17 * CURVE_BITS;
      if (fp_le(lhs, rhs)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic predict_force(input logic [31:0] word);
    int          g;
    int          tgt;
    int          curved;
    int          mag;
    int          dm;
    int          dd;
    force_word_t want;
    g   = $signed(word[15:0]);
    tgt = $signed(word[31:16]);
    if (g > G_CLAMP) g = G_CLAMP;
    if (g < -G_CLAMP) g = -G_CLAMP;
    if (g < 0) g = -g;
    curved = curve_lut[g >> (13 - CURVE_BITS)];
    if (hist_fill < HIST_DEPTH) hist_fill++;
    else hist_sum -= hist[hist_slot];
    hist[hist_slot] = curved;
    hist_sum += curved;
    hist_slot = (hist_slot + 1) % HIST_DEPTH;
    mag = hist_sum / hist_fill;
    blend_dir = (4 * blend_dir + tgt) / 5;
    dm = mag - last_sent_mag;
    if (dm < 0) dm = -dm;
    dd = blend_dir - tgt;
    if (dd < 0) dd = -dd;
    want.mag = 14'(mag);
    want.dir = 16'(blend_dir);
    if (dm < min_change && dd < dir_tol) begin
      suppressed++;
    end else begin
      last_sent_mag = mag;
    end
    if (row_typed) begin
      if (row_emits) begin
        want.mag = row_mag;
        want.dir = row_dir;
        queue_word(want);
      end
    end else if (!(dm < min_change && dd < dir_tol)) begin
      queue_word(want);
    end
  endtask

  task automatic check_force(input logic [31:0] word);
    force_word_t want;
    results_seen++;
    if (exp_count == 0) begin
      report_mismatch($sformatf("unexpected result word %h", word));
    end else begin
      want = exp_words[exp_head];
      exp_head = (exp_head + 1) % EXP_DEPTH;
      exp_count--;
      if (word[13:0] !== want.mag)
        report_mismatch($sformatf("magnitude %0d, expected %0d", word[13:0], want.mag));
      if (word[29:14] !== want.dir)
        report_mismatch($sformatf("direction %0d, expected %0d",
                                  $signed(word[29:14]), want.dir));
      if (word[31:30] !== 2'b00)
        report_mismatch($sformatf("pad bits %b not zero", word[31:30]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_force(m_tdata);
      if (s_tvalid && s_tready) predict_force(s_tdata);
    end
  end

  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(input logic signed [15:0] g, input logic signed [15:0] tgt,
                           input bit typed, input bit emits, input bit [13:0] mag,
                           input logic signed [15:0] dir);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    row_typed = typed;
    row_emits = emits;
    row_mag   = mag;
    row_dir   = dir;
    s_tvalid <= 1'b1;
    s_tdata  <= {tgt, g};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == CFG_MIN_MAG) min_change = int'(val[MAG_W-1:0]);
    else if (idx == CFG_DIR_TOL) dir_tol = int'(val);
  endtask

  // stop sending, wait for every expected word, then let dropped items finish
  task automatic drain();
    int waited;
    @(negedge clk);
    s_tvalid <= 1'b0;
    for (waited = 0; exp_count != 0 && waited < 4000; waited++)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] g;
    logic signed [15:0] tgt;
    logic signed [15:0] hold_tgt;
    int                 g_walk;
    int                 set_min [N_PHASES];
    int                 set_tol [N_PHASES];

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    row_typed = 1'b0;
    row_emits = 1'b0;
    row_mag   = '0;
    row_dir   = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    suppressed = 0;
    exp_head  = 0;
    exp_tail  = 0;
    exp_count = 0;

    for (int i = 0; i < CURVE_SIZE; i++) curve_lut[i] = curve_value(i);
    for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 0;
    hist_fill     = 0;
    hist_slot     = 0;
    hist_sum      = 0;
    blend_dir     = 0;
    last_sent_mag = -1;
    min_change    = int'(MIN_MAG_RESET);
    dir_tol       = int'(DIR_TOL_RESET);

    // g, target, typed, emits, magnitude, direction
    directed_rows = '{
      '{16'sd0,      16'sd0,      1'b1, 1'b0, 14'd0,     16'sd0},
      '{16'sh8000,   16'sd0,      1'b1, 1'b1, 14'd5000,  16'sd0},
      '{16'sd32767,  16'sd0,      1'b1, 1'b1, 14'd6666,  16'sd0},
      '{16'sd8192,   16'sd0,      1'b1, 1'b1, 14'd7500,  16'sd0},
      '{-16'sd8192,  16'sd32767,  1'b1, 1'b1, 14'd8000,  16'sd6553},
      '{16'sd8192,   16'sh8000,   1'b1, 1'b1, 14'd10000, -16'sd1311},
      '{16'sd8192,   -16'sd1311,  1'b1, 1'b0, 14'd0,     16'sd0},
      '{16'sd8193,   -16'sd1311,  1'b0, 1'b0, 14'd0,     16'sd0},
      '{-16'sd8193,  -16'sd1311,  1'b0, 1'b0, 14'd0,     16'sd0},
      '{16'sd8191,   -16'sd1311,  1'b0, 1'b0, 14'd0,     16'sd0},
      '{16'sd7,      -16'sd1311,  1'b0, 1'b0, 14'd0,     16'sd0},
      '{16'sd8,      -16'sd1311,  1'b0, 1'b0, 14'd0,     16'sd0},
      '{-16'sd9,     16'sd0,      1'b0, 1'b0, 14'd0,     16'sd0},
      '{-16'sd1,     16'sd32767,  1'b0, 1'b0, 14'd0,     16'sd0},
      '{16'sd16384,  16'sd32767,  1'b0, 1'b0, 14'd0,     16'sd0},
      '{-16'sd16385, 16'sh8000,   1'b0, 1'b0, 14'd0,     16'sd0},
      '{16'sd1000,   16'sh8000,   1'b0, 1'b0, 14'd0,     16'sd0},
      '{16'sd2000,   16'sh8000,   1'b0, 1'b0, 14'd0,     16'sd0},
      '{16'sd4096,   16'sd1,      1'b0, 1'b0, 14'd0,     16'sd0},
      '{-16'sd4096,  -16'sd1,     1'b0, 1'b0, 14'd0,     16'sd0}
    };

    set_min = '{0, 10000, 16'hFFFF, 0, 100, 0, 0, 0};
    set_tol = '{0, 65535, 0, 65535, 500, 0, 0, 0};
    for (int p = 5; p < N_PHASES; p++) begin
      set_min[p] = $urandom_range(0, 400);
      set_tol[p] = $urandom_range(0, 4000);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].g, directed_rows[i].tgt, directed_rows[i].typed,
                directed_rows[i].emits, directed_rows[i].mag, directed_rows[i].dir);
    drain();

    g_walk   = 0;
    hold_tgt = 16'($urandom);
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_MIN_MAG, 16'(set_min[p]));
      write_reg(CFG_DIR_TOL, 16'(set_tol[p]));
      // unmapped indexes must not disturb either register
      write_reg(CFG_SPARE0, 16'($urandom));
      write_reg(CFG_SPARE1, 16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 15) == 0) begin
          hold_tgt = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 4000) - 2000);
        end
        case ($urandom_range(0, 7))
          0: g = 16'($urandom);
          1: g = $urandom_range(0, 1) ? 16'sd8192 : -16'sd8192;
          2: g = 16'($urandom_range(0, 15) - 8);
          default: begin
            g_walk = g_walk + int'($urandom_range(0, 800)) - 400;
            if (g_walk > 9000) g_walk = 9000;
            if (g_walk < -9000) g_walk = -9000;
            g = 16'(g_walk);
          end
        endcase
        tgt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : hold_tgt;
        send_item(g, tgt, 1'b0, 1'b0, 14'd0, 16'sd0);
      end
      quiet = 1'b0;
      drain();
    end

    if (exp_count != 0)
      report_mismatch($sformatf("%0d expected results never arrived", exp_count));

    $display("sent %0d samples over %0d register settings, %0d force words checked",
             items_sent, N_PHASES + 1, results_seen);
    $display("%0d samples were held back as settled", suppressed);
    if (errors == 0) begin
      $display("lateral_force_conditioner_tb passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("lateral_force_conditioner_tb failed");
    end
    $finish;
  end

endmodule

// ===== lateral_force_conditioner.f =====
rtl/core/lfc_pkg.sv
rtl/core/lfc_ctrl.sv
rtl/core/lfc_datapath.sv
rtl/core/lateral_force_conditioner.sv
bench/lateral_force_conditioner_tb.sv
